// ===== rtl/rib_pkg.sv =====
// shared types and constants for the rc ibus frame receiver
// used by rib_ctrl, rib_datapath and rc_ibus_frame_receiver; no dependencies
`timescale 1ns / 1ps

package rib_pkg;

   // frame limits
   localparam int unsigned MAX_CHANNELS = 14;
   localparam int unsigned CH_IDX_W     = 4;
   localparam int unsigned POS_W        = 5;

   // checksum is this value minus the byte sum
   localparam logic [15:0] CKSUM_BASE = 16'hFFFF;

   // port widths
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned REQ_USER_W = 1;
   localparam int unsigned RSP_DATA_W = 88;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 8;

   // register reset values
   localparam logic [3:0] CHAN_RESET  = 4'd14;
   localparam logic [7:0] HDR1_RESET  = 8'd32;
   localparam logic [7:0] HDR2_RESET  = 8'd64;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER1  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER2  = 2'd2;

   // request kinds
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // parser phase
   typedef enum logic [3:0] {
      PH_HUNT_FIRST  = 4'b0001,
      PH_HUNT_SECOND = 4'b0010,
      PH_PAYLOAD     = 4'b0100,
      PH_CHECKSUM    = 4'b1000
   } phase_type;

   // controller state
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic                step;      // apply the accepted request
      logic                load;      // load one result into the output register
      logic [CH_IDX_W-1:0] idx;       // channel index of that result
      logic                last;      // that result closes the frame
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic                frame_end; // the pending request completes a frame
      logic [CH_IDX_W-1:0] count;     // results of the completed frame
      logic                out_free;  // output register can take a result
   } status_type;

endpackage

// ===== rtl/rib_ctrl.sv =====
// controller for the rc ibus frame receiver: request handshake and result sequencing
// depends on rib_pkg
`timescale 1ns / 1ps

module rib_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  rib_pkg::status_type   status,
   output rib_pkg::cmd_type      cmd
);

   rib_pkg::state_type state_ff, state_in;
   logic [rib_pkg::CH_IDX_W-1:0] idx_ff, idx_in;
   logic [rib_pkg::CH_IDX_W-1:0] idx_next;

   assign req_tready = (state_ff == rib_pkg::ST_IDLE);
   assign idx_next   = rib_pkg::CH_IDX_W'(idx_ff + 1'b1);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd.step = 1'b0;
      cmd.load = 1'b0;
      cmd.idx  = idx_ff;
      cmd.last = (idx_next == status.count);
      case (state_ff)
         rib_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd.step = 1'b1;
               if (status.frame_end) begin
                  state_in = rib_pkg::ST_EMIT;
                  idx_in   = '0;
               end
            end
         end
         rib_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               if (idx_next == status.count) begin
                  state_in = rib_pkg::ST_IDLE;
               end else begin
                  idx_in = idx_next;
               end
            end
         end
         default: begin
            state_in = rib_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rib_pkg::ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ===== rtl/rib_datapath.sv =====
// datapath for the rc ibus frame receiver: parser, channel store, counters, output register
// depends on rib_pkg
`timescale 1ns / 1ps

module rib_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [rib_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [rib_pkg::REQ_USER_W-1:0]    req_tuser,
   input  logic                              csr_we,
   input  logic [rib_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rib_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  rib_pkg::cmd_type                  cmd,
   output rib_pkg::status_type               status,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rib_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast
);

   // configuration
   logic [3:0] chan_ff, chan_in;
   logic [7:0] hdr1_ff, hdr1_in;
   logic [7:0] hdr2_ff, hdr2_in;

   // parser
   rib_pkg::phase_type          phase_ff, phase_in;
   logic [rib_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [15:0]                 sum_ff, sum_in;
   logic [7:0]                  low_ff, low_in;
   logic [15:0]                 store_ff [rib_pkg::MAX_CHANNELS];

   // frame status
   logic [31:0] dropped_ff, dropped_in;
   logic [31:0] ms_ff, ms_in;
   logic [31:0] prev_ff, prev_in;
   logic        link_ff, link_in;
   logic [31:0] interval_ff, interval_in;
   logic        good_ff, good_in;
   logic [rib_pkg::CH_IDX_W-1:0] count_ff, count_in;

   // output register
   logic        valid_ff, valid_in;
   logic [rib_pkg::CH_IDX_W-1:0] oidx_ff;
   logic [15:0] oval_ff;
   logic        olast_ff, ogood_ff, olink_ff;
   logic [31:0] odrop_ff, oint_ff;

   logic [7:0]  rx;
   logic        is_tick;
   logic [rib_pkg::CH_IDX_W-1:0] eff;
   logic [rib_pkg::POS_W-1:0]    nbytes;
   logic [15:0] received;
   logic [15:0] expected;
   logic        wr_en;
   logic [rib_pkg::CH_IDX_W-1:0] wr_addr;
   logic [15:0] rd_data;

   assign rx       = req_tdata[7:0];
   assign is_tick  = (req_tuser[0] == rib_pkg::OP_TICK);
   assign received = {rx, low_ff};
   assign expected = rib_pkg::CKSUM_BASE - sum_ff;
   assign wr_addr  = pos_ff[rib_pkg::POS_W-1:1];
   assign rd_data  = store_ff[cmd.idx];

   // clamp the channel count to 1..MAX_CHANNELS
   always_comb begin
      if (chan_ff == '0) begin
         eff = rib_pkg::CH_IDX_W'(1);
      end else if (chan_ff > rib_pkg::CH_IDX_W'(rib_pkg::MAX_CHANNELS)) begin
         eff = rib_pkg::CH_IDX_W'(rib_pkg::MAX_CHANNELS);
      end else begin
         eff = chan_ff;
      end
      nbytes = {eff, 1'b0};
   end

   assign status.frame_end = !is_tick && (phase_ff == rib_pkg::PH_CHECKSUM) && (pos_ff != '0);
   assign status.count     = count_ff;
   assign status.out_free  = !valid_ff || rsp_tready;

   // configuration writes
   always_comb begin
      chan_in = chan_ff;
      hdr1_in = hdr1_ff;
      hdr2_in = hdr2_ff;
      if (csr_we) begin
         case (csr_index)
            rib_pkg::CSR_CHANNELS: chan_in = csr_wdata[3:0];
            rib_pkg::CSR_HEADER1:  hdr1_in = csr_wdata;
            rib_pkg::CSR_HEADER2:  hdr2_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // parser and frame bookkeeping
   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      sum_in      = sum_ff;
      low_in      = low_ff;
      dropped_in  = dropped_ff;
      ms_in       = ms_ff;
      prev_in     = prev_ff;
      link_in     = link_ff;
      interval_in = interval_ff;
      good_in     = good_ff;
      count_in    = count_ff;
      wr_en       = 1'b0;
      if (cmd.step) begin
         if (is_tick) begin
            ms_in = ms_ff + 32'd1;
         end else begin
            case (phase_ff)
               rib_pkg::PH_HUNT_FIRST: begin
                  if (rx == hdr1_ff) begin
                     sum_in   = {8'd0, rx};
                     phase_in = rib_pkg::PH_HUNT_SECOND;
                  end
               end
               rib_pkg::PH_HUNT_SECOND: begin
                  if (rx == hdr2_ff) begin
                     sum_in   = sum_ff + {8'd0, rx};
                     phase_in = rib_pkg::PH_PAYLOAD;
                     pos_in   = '0;
                  end else if (rx == hdr1_ff) begin
                     sum_in = {8'd0, rx};
                  end else begin
                     phase_in = rib_pkg::PH_HUNT_FIRST;
                  end
               end
               rib_pkg::PH_PAYLOAD: begin
                  if (pos_ff >= nbytes) begin
                     // count shrank mid-frame: this byte opens the checksum
                     low_in   = rx;
                     phase_in = rib_pkg::PH_CHECKSUM;
                     pos_in   = rib_pkg::POS_W'(1);
                  end else begin
                     if (!pos_ff[0]) begin
                        low_in = rx;
                     end else begin
                        wr_en = 1'b1;
                     end
                     sum_in = sum_ff + {8'd0, rx};
                     pos_in = rib_pkg::POS_W'(pos_ff + 1'b1);
                     if (rib_pkg::POS_W'(pos_ff + 1'b1) >= nbytes) begin
                        phase_in = rib_pkg::PH_CHECKSUM;
                        pos_in   = '0;
                     end
                  end
               end
               rib_pkg::PH_CHECKSUM: begin
                  if (pos_ff == '0) begin
                     low_in = rx;
                     pos_in = rib_pkg::POS_W'(1);
                  end else begin
                     phase_in = rib_pkg::PH_HUNT_FIRST;
                     pos_in   = '0;
                     if (received != expected) begin
                        dropped_in  = dropped_ff + 32'd1;
                        good_in     = 1'b0;
                        interval_in = '0;
                        count_in    = rib_pkg::CH_IDX_W'(1);
                     end else begin
                        interval_in = ms_ff - prev_ff;
                        prev_in     = ms_ff;
                        link_in     = 1'b1;
                        good_in     = 1'b1;
                        count_in    = eff;
                     end
                  end
               end
               default: begin
                  phase_in = rib_pkg::PH_HUNT_FIRST;
               end
            endcase
         end
      end
   end

   // output register occupancy
   always_comb begin
      if (cmd.load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff     <= rib_pkg::CHAN_RESET;
         hdr1_ff     <= rib_pkg::HDR1_RESET;
         hdr2_ff     <= rib_pkg::HDR2_RESET;
         phase_ff    <= rib_pkg::PH_HUNT_FIRST;
         pos_ff      <= '0;
         sum_ff      <= '0;
         low_ff      <= '0;
         dropped_ff  <= '0;
         ms_ff       <= '0;
         prev_ff     <= '0;
         link_ff     <= 1'b0;
         interval_ff <= '0;
         good_ff     <= 1'b0;
         count_ff    <= rib_pkg::CH_IDX_W'(1);
         valid_ff    <= 1'b0;
      end else begin
         chan_ff     <= chan_in;
         hdr1_ff     <= hdr1_in;
         hdr2_ff     <= hdr2_in;
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         sum_ff      <= sum_in;
         low_ff      <= low_in;
         dropped_ff  <= dropped_in;
         ms_ff       <= ms_in;
         prev_ff     <= prev_in;
         link_ff     <= link_in;
         interval_ff <= interval_in;
         good_ff     <= good_in;
         count_ff    <= count_in;
         valid_ff    <= valid_in;
      end
   end

   // channel store, written on each high byte
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= {rx, low_ff};
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         oidx_ff  <= good_ff ? cmd.idx : '0;
         oval_ff  <= good_ff ? rd_data : 16'd0;
         olast_ff <= cmd.last;
         ogood_ff <= good_ff;
         odrop_ff <= dropped_ff;
         oint_ff  <= interval_ff;
         olink_ff <= link_ff;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {2'b00, olink_ff, oint_ff, odrop_ff, ogood_ff, oval_ff, oidx_ff};

endmodule

// ===== rtl/rc_ibus_frame_receiver.sv =====
// top level of the rc ibus frame receiver: controller plus datapath
// depends on rib_pkg, rib_ctrl and rib_datapath
`timescale 1ns / 1ps

// Receives serial bytes and millisecond ticks on the request stream and hunts
// byte by byte for a two-byte header, then channels_in_use little-endian channel
// words and a 16-bit checksum (0xFFFF minus the sum of all earlier frame bytes).
// A good frame yields one response per channel with tlast on the last; a bad
// frame yields one response with frame_good low and bumps the dropped count.
// Each byte or tick request is taken while the controller is idle. After the
// request that completes a frame, requests are held off while the responses
// are loaded one at a time into the single output register, and longer while
// the response side stalls; once the last response is loaded, a waiting
// response never blocks the next request.
// Configuration writes are taken at any time and act at once.

module rc_ibus_frame_receiver (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rib_pkg::REQ_DATA_W-1:0]    req_tdata,  // rx_byte
   input  logic [rib_pkg::REQ_USER_W-1:0]    req_tuser,  // operation
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // channel_index[3:0], channel_value[19:4], frame_good[20], dropped_count[52:21],
   // interval_ms[84:53], link_seen[85], zero fill
   output logic [rib_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast,  // last_of_frame
   input  logic                              csr_we,
   input  logic [rib_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rib_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   rib_pkg::cmd_type    cmd;
   rib_pkg::status_type status;

   // request handshake and result sequencing
   rib_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // parser, store and output register
   rib_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
